// File: sv/pasw_pkg.sv
// shared constants, types and coefficient tables for the planar array steering weights block
package pasw_pkg;

  localparam int BEAMS     = 4;
  localparam int ANGLE_W   = 16;
  localparam int SPACING_W = 18;
  localparam int WEIGHT_W  = 16;
  localparam int ELEM_W    = 4;
  localparam int BEAM_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W     = 46;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HSPACE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VSPACE = 2'd1;

  localparam logic [SPACING_W-1:0] HSPACE_RESET = 18'd113080;
  localparam logic [SPACING_W-1:0] VSPACE_RESET = 18'd115090;

  // angle to turns: round(|a| * 2^22 / 90), in four reciprocal steps
  localparam logic [7:0] ANGLE_DIV   = 8'd90;
  localparam logic [7:0] ANGLE_ROUND = 8'd45;
  localparam int         DIV_STEPS   = 4;

  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
  localparam logic [29:0] EIGHTH     = 30'h2000_0000;

  // horner coefficient slots: sine first, then cosine
  localparam logic [3:0] SIN_FIRST = 4'd0;
  localparam logic [3:0] SIN_LAST  = 4'd4;
  localparam logic [3:0] COS_FIRST = 4'd5;
  localparam logic [3:0] COS_LAST  = 4'd10;

  localparam logic [31:0] RECIP_110 = 32'((64'd1 << 32) / 64'd110);
  localparam logic [31:0] RECIP_72  = 32'((64'd1 << 32) / 64'd72);
  localparam logic [31:0] RECIP_42  = 32'((64'd1 << 32) / 64'd42);
  localparam logic [31:0] RECIP_20  = 32'((64'd1 << 32) / 64'd20);
  localparam logic [31:0] RECIP_6   = 32'((64'd1 << 32) / 64'd6);
  localparam logic [31:0] RECIP_132 = 32'((64'd1 << 32) / 64'd132);
  localparam logic [31:0] RECIP_90  = 32'((64'd1 << 32) / 64'd90);
  localparam logic [31:0] RECIP_56  = 32'((64'd1 << 32) / 64'd56);
  localparam logic [31:0] RECIP_30  = 32'((64'd1 << 32) / 64'd30);
  localparam logic [31:0] RECIP_12  = 32'((64'd1 << 32) / 64'd12);
  localparam logic [31:0] RECIP_2   = 32'((64'd1 << 32) / 64'd2);

  typedef struct packed {
    logic signed [31:0] sin_v;
    logic signed [31:0] cos_v;
  } trig_res_t;

  // horner divisor per slot
  function automatic logic [7:0] poly_div(input logic [3:0] idx);
    logic [7:0] d;
    unique case (idx)
      4'd0:    d = 8'd110;
      4'd1:    d = 8'd72;
      4'd2:    d = 8'd42;
      4'd3:    d = 8'd20;
      4'd4:    d = 8'd6;
      4'd5:    d = 8'd132;
      4'd6:    d = 8'd90;
      4'd7:    d = 8'd56;
      4'd8:    d = 8'd30;
      4'd9:    d = 8'd12;
      4'd10:   d = 8'd2;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  // reciprocal 2^32/d per slot, floored
  function automatic logic [31:0] poly_recip(input logic [3:0] idx);
    logic [31:0] r;
    unique case (idx)
      4'd0:    r = RECIP_110;
      4'd1:    r = RECIP_72;
      4'd2:    r = RECIP_42;
      4'd3:    r = RECIP_20;
      4'd4:    r = RECIP_6;
      4'd5:    r = RECIP_132;
      4'd6:    r = RECIP_90;
      4'd7:    r = RECIP_56;
      4'd8:    r = RECIP_30;
      4'd9:    r = RECIP_12;
      4'd10:   r = RECIP_2;
      default: r = 32'hFFFF_FFFF;
    endcase
    return r;
  endfunction

  // stored angles after reset, in 1/256 degree
  function automatic logic [ANGLE_W-1:0] reset_az(input logic [BEAM_W-1:0] b);
    logic [ANGLE_W-1:0] v;
    unique case (b)
      2'd0:    v = 16'hFE00;
      2'd1:    v = 16'h0200;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  function automatic logic [ANGLE_W-1:0] reset_el(input logic [BEAM_W-1:0] b);
    logic [ANGLE_W-1:0] v;
    unique case (b)
      2'd2:    v = 16'h0200;
      2'd3:    v = 16'hFE00;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

endpackage

// File: sv/planar_array_steering_weights.sv
// top level: beam angle store, angle conversion, cell chain and weight output
//
// Input channel (in_valid_i / in_ready_i handshake) takes one word: a beam
// number and its azimuth and elevation in 1/256 degree. If the pair equals
// the one stored for that beam the word is dropped and the block is ready
// again on the next cycle. Otherwise the pair is stored and ELEMENTS weight
// words follow on the output channel, element 0 first, last_o on the final one.
// The first weight needs two angle conversions (reciprocal division by
// 90), three sine/cosine evaluations and the path products. Every further
// weight needs one more evaluation on the shared multiplier of the
// sine/cosine unit, plus any receiver stall. No new word is taken until
// the last weight has entered the output register.
// The output register holds a weight while out_ready_i is low and the
// sequencer waits; the next input word is taken while the final weight waits.
// Reset restores the spacing registers and the per-beam angle pairs and
// produces no output. Spacings are written through cfg_we_i only while
// idle; the user must keep to this, as the block itself does not enforce it.
module planar_array_steering_weights
  import pasw_pkg::*;
#(
  parameter int ELEMENTS = 16,
  parameter int COLUMNS  = 4
)
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [SPACING_W-1:0]        cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [BEAM_W-1:0]           beam_i,
  input  logic signed [ANGLE_W-1:0]   azimuth_angle_i,
  input  logic signed [ANGLE_W-1:0]   elevation_angle_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [BEAM_W-1:0]           beam_out_o,
  output logic [ELEM_W-1:0]           element_o,
  output logic signed [WEIGHT_W-1:0]  weight_real_o,
  output logic signed [WEIGHT_W-1:0]  weight_imag_o,
  output logic                        last_o
);

  localparam int ROWS  = ELEMENTS / COLUMNS;
  localparam int CNT_W = $clog2(ELEMENTS);
  localparam logic [CNT_W-1:0] LAST_ELEM = CNT_W'(ELEMENTS - 1);
  localparam logic [1:0] DIV_LAST = 2'(DIV_STEPS - 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DIV    = 4'd1;
  localparam logic [3:0] ST_TSTART = 4'd2;
  localparam logic [3:0] ST_TWAIT  = 4'd3;
  localparam logic [3:0] ST_PROD   = 4'd4;
  localparam logic [3:0] ST_SPA    = 4'd5;
  localparam logic [3:0] ST_SPB    = 4'd6;
  localparam logic [3:0] ST_LOAD   = 4'd7;
  localparam logic [3:0] ST_ESTART = 4'd8;
  localparam logic [3:0] ST_EWAIT  = 4'd9;
  localparam logic [3:0] ST_EPUT   = 4'd10;

  function automatic logic [WEIGHT_W-1:0] scale_w(input logic signed [31:0] v);
    logic [31:0]        m;
    logic [46:0]        p;
    logic [WEIGHT_W-1:0] r;
    m = v[31] ? 32'(-v) : 32'(v);
    p = {m, 15'b0} - {15'b0, m};
    r = p[45:30];
    return v[31] ? ('0 - r) : r;
  endfunction

  logic [3:0]  st_q, st_d;
  logic [SPACING_W-1:0] hs_q, vs_q;
  logic [ANGLE_W-1:0] last_az_q [BEAMS];
  logic [ANGLE_W-1:0] last_el_q [BEAMS];

  logic                in_fire, changed, put_ok, trig_start, trig_done;
  logic [BEAM_W-1:0]   beam_q;
  logic [ANGLE_W-1:0]  az_q, el_q;
  logic                el_phase_q;
  logic [1:0]          div_cnt_q;
  logic [ANGLE_W:0]    cur_ext, cur_mag;
  logic [28:0]         div_x;
  logic [31:0]         div_mul_a, div_num, div_q_est, div_rem, div_quot;
  logic                div_ge;
  logic [63:0]         div_prod_q;
  logic [8:0]          hi_q;
  logic [6:0]          rm_q;
  logic [30:0]         quot_q;
  logic                cur_neg;
  logic [31:0]         turns, trig_phase, head_phase;
  trig_res_t           trig_res, wres_q;
  logic signed [31:0]  saz_q, sel_q, cel_q;
  logic signed [63:0]  prod_q;
  logic signed [31:0]  p30;
  logic [SUM_W-1:0]    a_q, b_q;
  logic [CNT_W-1:0]    elem_q;
  logic                cell_load, cell_shift;
  logic [31:0]         ph [ELEMENTS+1];

  logic                out_valid_q, last_q;
  logic [BEAM_W-1:0]   beam_out_q;
  logic [ELEM_W-1:0]   elem_out_q;
  logic [WEIGHT_W-1:0] wr_q, wi_q;

  // input handshake and change detect
  assign in_ready_o = (st_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign changed    = (last_az_q[beam_i] != azimuth_angle_i) ||
                      (last_el_q[beam_i] != elevation_angle_i);
  assign put_ok     = !out_valid_q || out_ready_i;

  // magnitude of the angle being converted
  assign cur_neg = el_phase_q ? el_q[ANGLE_W-1] : az_q[ANGLE_W-1];
  assign cur_ext = el_phase_q ? {el_q[ANGLE_W-1], el_q} : {az_q[ANGLE_W-1], az_q};
  assign cur_mag = cur_neg ? ('0 - cur_ext) : cur_ext;

  // division by 90 in two halves: magnitude first, then remainder * 2^22 + 45
  assign div_x     = {rm_q, 22'b0} + 29'(ANGLE_ROUND);
  assign div_mul_a = (div_cnt_q == 2'd0) ? 32'(cur_mag) : {3'b0, div_x};
  assign div_num   = (div_cnt_q == 2'd1) ? 32'(cur_mag) : {3'b0, div_x};
  assign div_q_est = div_prod_q[63:32];
  assign div_rem   = div_num - div_q_est * {24'b0, ANGLE_DIV};
  assign div_ge    = div_rem >= {24'b0, ANGLE_DIV};
  assign div_quot  = div_q_est + {31'b0, div_ge};
  assign turns     = cur_neg ? (32'd0 - {1'b0, quot_q}) : {1'b0, quot_q};

  assign trig_start = (st_q == ST_TSTART) || (st_q == ST_ESTART);
  assign trig_phase = (st_q == ST_ESTART) ? head_phase : turns;
  assign p30        = signed'(prod_q[61:30]);

  pasw_trig u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (trig_start),
    .phase_i (trig_phase),
    .done_o  (trig_done),
    .res_o   (trig_res)
  );

  // element cell chain, head feeds the trig unit
  assign cell_load  = (st_q == ST_LOAD);
  assign cell_shift = (st_q == ST_EPUT) && put_ok;
  assign ph[ELEMENTS] = '0;
  assign head_phase   = ph[0];

  for (genvar k = 0; k < ELEMENTS; k++) begin : g_cell
    localparam int CC = k % COLUMNS;
    localparam int RR = k / COLUMNS;
    pasw_cell #(
      .YC (2 * CC - (COLUMNS - 1)),
      .ZC ((ROWS - 1) - 2 * RR)
    ) u_cell (
      .clk_i   (clk_i),
      .load_i  (cell_load),
      .shift_i (cell_shift),
      .a_i     (a_q),
      .b_i     (b_q),
      .phase_i (ph[k+1]),
      .phase_o (ph[k])
    );
  end

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_fire && changed) begin
          st_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt_q == DIV_LAST) begin
          st_d = ST_TSTART;
        end
      end
      ST_TSTART: st_d = ST_TWAIT;
      ST_TWAIT: begin
        if (trig_done) begin
          st_d = el_phase_q ? ST_PROD : ST_DIV;
        end
      end
      ST_PROD:   st_d = ST_SPA;
      ST_SPA:    st_d = ST_SPB;
      ST_SPB:    st_d = ST_LOAD;
      ST_LOAD:   st_d = ST_ESTART;
      ST_ESTART: st_d = ST_EWAIT;
      ST_EWAIT: begin
        if (trig_done) begin
          st_d = ST_EPUT;
        end
      end
      ST_EPUT: begin
        if (put_ok) begin
          st_d = (elem_q == LAST_ELEM) ? ST_IDLE : ST_ESTART;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      hs_q        <= HSPACE_RESET;
      vs_q        <= VSPACE_RESET;
      el_phase_q  <= 1'b0;
      div_cnt_q   <= '0;
      elem_q      <= '0;
      out_valid_q <= 1'b0;
      for (int b = 0; b < BEAMS; b++) begin
        last_az_q[b] <= reset_az(BEAM_W'(b));
        last_el_q[b] <= reset_el(BEAM_W'(b));
      end
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_HSPACE: hs_q <= cfg_data_i;
          REG_VSPACE: vs_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_fire && changed) begin
        last_az_q[beam_i] <= azimuth_angle_i;
        last_el_q[beam_i] <= elevation_angle_i;
        el_phase_q        <= 1'b0;
        div_cnt_q         <= '0;
      end
      if (st_q == ST_DIV) begin
        div_cnt_q <= div_cnt_q + 2'd1;
      end
      if (st_q == ST_TWAIT && trig_done && !el_phase_q) begin
        el_phase_q <= 1'b1;
        div_cnt_q  <= '0;
      end
      if (st_q == ST_LOAD) begin
        elem_q <= '0;
      end
      if (cell_shift) begin
        elem_q <= elem_q + CNT_W'(1);
      end
      if (cell_shift) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire && changed) begin
      beam_q <= beam_i;
      az_q   <= azimuth_angle_i;
      el_q   <= elevation_angle_i;
    end
    if (st_q == ST_DIV) begin
      if (!div_cnt_q[0]) begin
        div_prod_q <= {32'b0, div_mul_a} * {32'b0, RECIP_90};
      end
      if (div_cnt_q == 2'd1) begin
        hi_q <= div_quot[8:0];
        rm_q <= div_ge ? 7'(div_rem - {24'b0, ANGLE_DIV}) : 7'(div_rem);
      end
      if (div_cnt_q == 2'd3) begin
        quot_q <= {hi_q, div_quot[21:0]};
      end
    end
    if (st_q == ST_TWAIT && trig_done) begin
      if (el_phase_q) begin
        sel_q <= trig_res.sin_v;
        cel_q <= trig_res.cos_v;
      end else begin
        saz_q <= trig_res.sin_v;
      end
    end
    if (st_q == ST_PROD) begin
      prod_q <= 64'(cel_q) * 64'(saz_q);
    end
    if (st_q == ST_SPA) begin
      a_q <= SUM_W'(64'(p30) * 64'($signed({1'b0, hs_q})));
    end
    if (st_q == ST_SPB) begin
      b_q <= SUM_W'(64'(sel_q) * 64'($signed({1'b0, vs_q})));
    end
    if (st_q == ST_EWAIT && trig_done) begin
      wres_q <= trig_res;
    end
    if (cell_shift) begin
      beam_out_q <= beam_q;
      elem_out_q <= ELEM_W'(elem_q);
      wr_q       <= scale_w(wres_q.cos_v);
      wi_q       <= scale_w(wres_q.sin_v);
      last_q     <= (elem_q == LAST_ELEM);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign beam_out_o    = beam_out_q;
  assign element_o     = elem_out_q;
  assign weight_real_o = signed'(wr_q);
  assign weight_imag_o = signed'(wi_q);
  assign last_o        = last_q;

  // element counter never runs past the array
  a_elem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    elem_q <= LAST_ELEM)
    else $error("element counter out of range");

  // trig results only arrive while the sequencer waits for them
  a_trig_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig_done |-> (st_q == ST_TWAIT || st_q == ST_EWAIT))
    else $error("trig result with no waiting state");

  // a held weight is never overwritten
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EPUT && out_valid_q && !out_ready_i) |=> (st_q == ST_EPUT))
    else $error("weight overwritten while stalled");

  // a changed pair starts the angle conversion
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && changed) |=> (st_q == ST_DIV && !el_phase_q))
    else $error("changed angles did not start an update");

endmodule

// File: sv/pasw_trig.sv
// iterative sine and cosine of a q32 turn, one shared multiplier, horner series
module pasw_trig
  import pasw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] phase_i,
  output logic        done_o,
  output trig_res_t   res_o
);

  localparam logic [3:0] T_IDLE = 4'd0;
  localparam logic [3:0] T_TH   = 4'd1;
  localparam logic [3:0] T_T    = 4'd2;
  localparam logic [3:0] T_REC  = 4'd3;
  localparam logic [3:0] T_COR  = 4'd4;
  localparam logic [3:0] T_MT   = 4'd5;
  localparam logic [3:0] T_MS   = 4'd6;
  localparam logic [3:0] T_SV   = 4'd7;

  logic [3:0]  st_q, st_d;
  logic [3:0]  idx_q, idx_d;
  logic        done_q, done_d;
  logic [1:0]  quad_q;
  logic        swap_q;
  logic [29:0] th_q, t_q;
  logic [30:0] acc_q, m_q, s_q;
  logic [63:0] prod_q, prod_n;
  trig_res_t   res_q, res_n;

  logic [29:0] x_in, xf;
  logic        fold;
  logic [31:0] mul_a;
  logic [32:0] mul_b;
  logic [30:0] mval;
  logic [31:0] q_est, qd, rem, qq;
  logic [7:0]  dsel;
  logic [30:0] acc_n, a_v, b_v;
  logic signed [31:0] sa, sb;

  // octant fold
  assign x_in = phase_i[29:0];
  assign fold = x_in > EIGHTH;
  assign xf   = fold ? 30'({1'b0, Q30_ONE} - {2'b0, x_in}) : x_in;

  // reciprocal quotient with one correction step
  assign q_est = prod_q[63:32];
  assign dsel  = poly_div(idx_q);
  assign qd    = q_est * {24'b0, dsel};
  assign rem   = {1'b0, m_q} - qd;
  assign qq    = q_est + {31'b0, (rem >= {24'b0, dsel})};
  assign acc_n = 31'({1'b0, Q30_ONE} - qq);

  // quadrant mapping of the finished pair
  assign a_v = swap_q ? acc_n : s_q;
  assign b_v = swap_q ? s_q : acc_n;
  assign sa  = signed'({1'b0, a_v});
  assign sb  = signed'({1'b0, b_v});

  always_comb begin
    unique case (quad_q)
      2'd0: begin
        res_n.sin_v = sa;
        res_n.cos_v = sb;
      end
      2'd1: begin
        res_n.sin_v = sb;
        res_n.cos_v = -sa;
      end
      2'd2: begin
        res_n.sin_v = -sa;
        res_n.cos_v = -sb;
      end
      default: begin
        res_n.sin_v = -sb;
        res_n.cos_v = sa;
      end
    endcase
  end

  // sequencer and multiplier operand select
  always_comb begin
    st_d   = st_q;
    idx_d  = idx_q;
    done_d = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    mval   = '0;
    unique case (st_q)
      T_IDLE: begin
        mul_a = {2'b0, xf};
        mul_b = TWO_PI_Q30;
        if (start_i) begin
          st_d = T_TH;
        end
      end
      T_TH: begin
        mul_a = {2'b0, prod_q[61:32]};
        mul_b = {3'b0, prod_q[61:32]};
        st_d  = T_T;
      end
      T_T: begin
        mval  = {1'b0, prod_q[59:30]};
        mul_a = {1'b0, mval};
        mul_b = {1'b0, poly_recip(SIN_FIRST)};
        idx_d = SIN_FIRST;
        st_d  = T_COR;
      end
      T_REC: begin
        mval  = prod_q[60:30];
        mul_a = {1'b0, mval};
        mul_b = {1'b0, poly_recip(idx_q)};
        st_d  = T_COR;
      end
      T_COR: begin
        if (idx_q == SIN_LAST) begin
          st_d = T_MS;
        end else if (idx_q == COS_LAST) begin
          st_d   = T_IDLE;
          done_d = 1'b1;
        end else begin
          st_d = T_MT;
        end
      end
      T_MT: begin
        mul_a = {2'b0, t_q};
        mul_b = {2'b0, acc_q};
        idx_d = idx_q + 4'd1;
        st_d  = T_REC;
      end
      T_MS: begin
        mul_a = {2'b0, th_q};
        mul_b = {2'b0, acc_q};
        st_d  = T_SV;
      end
      T_SV: begin
        mval  = {1'b0, t_q};
        mul_a = {1'b0, mval};
        mul_b = {1'b0, poly_recip(COS_FIRST)};
        idx_d = COS_FIRST;
        st_d  = T_COR;
      end
      default: begin
        st_d = T_IDLE;
      end
    endcase
  end

  assign prod_n = {32'b0, mul_a} * {31'b0, mul_b};

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= T_IDLE;
      idx_q  <= SIN_FIRST;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      idx_q  <= idx_d;
      done_q <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_n;
    m_q    <= mval;
    if (st_q == T_IDLE && start_i) begin
      quad_q <= phase_i[31:30];
      swap_q <= fold;
    end
    if (st_q == T_TH) begin
      th_q <= prod_q[61:32];
    end
    if (st_q == T_T) begin
      t_q <= prod_q[59:30];
    end
    if (st_q == T_SV) begin
      s_q <= prod_q[60:30];
    end
    if (st_q == T_COR) begin
      acc_q <= acc_n;
      if (idx_q == COS_LAST) begin
        res_q <= res_n;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: sv/pasw_cell.sv
// one element cell: forms its phase from the path terms and passes it down the chain
module pasw_cell
  import pasw_pkg::*;
#(
  parameter int YC = 0,
  parameter int ZC = 0
)
(
  input  logic             clk_i,
  input  logic             load_i,
  input  logic             shift_i,
  input  logic [SUM_W-1:0] a_i,
  input  logic [SUM_W-1:0] b_i,
  input  logic [31:0]      phase_i,
  output logic [31:0]      phase_o
);

  localparam logic [SUM_W-1:0] YC_V = SUM_W'(YC);
  localparam logic [SUM_W-1:0] ZC_V = SUM_W'(ZC);

  logic [SUM_W-1:0] sum, neg;
  logic [31:0]      phase_q;

  // path sum modulo 2^46, negated and floored to q32 turns
  assign sum = a_i * YC_V + b_i * ZC_V;
  assign neg = '0 - sum;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      phase_q <= neg[SUM_W-1:14];
    end else if (shift_i) begin
      phase_q <= phase_i;
    end
  end

  assign phase_o = phase_q;

endmodule

// File: sim/planar_array_steering_weights_checker.sv
// checker for the steering weights block: tracks the beam angles, predicts weights, compares
`timescale 1ns / 100ps

module planar_array_steering_weights_checker
  import pasw_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [SPACING_W-1:0]        cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [BEAM_W-1:0]           beam_i,
  input  logic signed [ANGLE_W-1:0]   azimuth_angle_i,
  input  logic signed [ANGLE_W-1:0]   elevation_angle_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [BEAM_W-1:0]           beam_out_i,
  input  logic [ELEM_W-1:0]           element_i,
  input  logic signed [WEIGHT_W-1:0]  weight_real_i,
  input  logic signed [WEIGHT_W-1:0]  weight_imag_i,
  input  logic                        last_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  localparam int N_ELEM = 16;
  localparam int N_COL  = 4;
  localparam int N_ROW  = N_ELEM / N_COL;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef struct {
    logic [BEAM_W-1:0]          beam;
    logic [ELEM_W-1:0]          elem;
    logic signed [WEIGHT_W-1:0] re;
    logic signed [WEIGHT_W-1:0] im;
    logic                       last;
  } weight_word_t;

  weight_word_t          weight_q[$];
  logic [SPACING_W-1:0]  h_space, v_space;
  logic [ANGLE_W-1:0]    stored_az [BEAMS];
  logic [ANGLE_W-1:0]    stored_el [BEAMS];
  int                    fails;

  assign fail_count_o = fails;
  assign pending_o    = weight_q.size();

  // angle in 1/256 degree to a q32 fraction of a turn
  function automatic logic [31:0] angle_turns(input logic signed [ANGLE_W-1:0] a);
    longint unsigned m, v;
    m = (a < 0) ? longint'(-int'(a)) : longint'(a);
    v = ((m << 22) + 45) / 90;
    if (a < 0) v = 64'd0 - v;
    return v[31:0];
  endfunction

  // taylor sine and cosine over one octant, q30
  function automatic void octant_series(input longint unsigned x,
                                        output longint unsigned s,
                                        output longint unsigned c);
    longint unsigned th, t, u, v;
    th = (x * longint'(TWO_PI_Q30)) >> 32;
    t  = (th * th) >> 30;
    u = ONE_Q30 - t / 110;
    u = ONE_Q30 - ((t * u) >> 30) / 72;
    u = ONE_Q30 - ((t * u) >> 30) / 42;
    u = ONE_Q30 - ((t * u) >> 30) / 20;
    u = ONE_Q30 - ((t * u) >> 30) / 6;
    s = (th * u) >> 30;
    v = ONE_Q30 - t / 132;
    v = ONE_Q30 - ((t * v) >> 30) / 90;
    v = ONE_Q30 - ((t * v) >> 30) / 56;
    v = ONE_Q30 - ((t * v) >> 30) / 30;
    v = ONE_Q30 - ((t * v) >> 30) / 12;
    v = ONE_Q30 - ((t * v) >> 30) / 2;
    c = v;
  endfunction

  // quadrant unfold around the octant series
  function automatic void trig_of_turns(input logic [31:0] ph,
                                        output longint sn, output longint cs);
    longint unsigned x, s, c;
    longint a, b;
    x = ph[29:0];
    if (x <= (ONE_Q30 >> 1)) octant_series(x, s, c);
    else octant_series(ONE_Q30 - x, c, s);
    a = s;
    b = c;
    case (ph[31:30])
      2'd0: begin sn = a;  cs = b;  end
      2'd1: begin sn = b;  cs = -a; end
      2'd2: begin sn = -a; cs = -b; end
      default: begin sn = -b; cs = a; end
    endcase
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] weight_scale(input longint v);
    longint unsigned m, r;
    m = (v < 0) ? -v : v;
    r = (m * 32767) >> 30;
    if (v < 0) r = 64'd0 - r;
    return r[WEIGHT_W-1:0];
  endfunction

  // push the sixteen weights of one beam update
  task automatic predict_weights(input logic [BEAM_W-1:0] b,
                                 input logic signed [ANGLE_W-1:0] az,
                                 input logic signed [ANGLE_W-1:0] el);
    longint saz, caz, sel, cel, p30, sum, ws, wc, yc, zc;
    longint unsigned nsum;
    weight_word_t w;
    trig_of_turns(angle_turns(az), saz, caz);
    trig_of_turns(angle_turns(el), sel, cel);
    p30 = (cel * saz) >>> 30;
    for (int k = 0; k < N_ELEM; k++) begin
      yc   = 2 * (k % N_COL) - (N_COL - 1);
      zc   = (N_ROW - 1) - 2 * (k / N_COL);
      sum  = p30 * yc * longint'(h_space) + sel * zc * longint'(v_space);
      nsum = 64'd0 - sum;
      trig_of_turns(nsum[45:14], ws, wc);
      w.beam = b;
      w.elem = k[ELEM_W-1:0];
      w.re   = weight_scale(wc);
      w.im   = weight_scale(ws);
      w.last = (k == N_ELEM - 1);
      weight_q.push_back(w);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fails++;
  endtask

  initial fails = 0;

  // config writes, input words and output words
  always @(posedge clk_i or negedge rst_ni) begin
    weight_word_t w;
    if (!rst_ni) begin
      h_space = HSPACE_RESET;
      v_space = VSPACE_RESET;
      for (int b = 0; b < BEAMS; b++) begin
        stored_az[b] = reset_az(b[BEAM_W-1:0]);
        stored_el[b] = reset_el(b[BEAM_W-1:0]);
      end
      weight_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_HSPACE) h_space = cfg_data_i;
        else if (cfg_index_i == REG_VSPACE) v_space = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (weight_q.size() == 0) begin
          report_mismatch("weight word with none expected");
        end else begin
          w = weight_q.pop_front();
          if (beam_out_i !== w.beam)
            report_mismatch($sformatf("beam %0d want %0d", beam_out_i, w.beam));
          if (element_i !== w.elem)
            report_mismatch($sformatf("element %0d want %0d", element_i, w.elem));
          if (weight_real_i !== w.re)
            report_mismatch($sformatf("beam %0d elem %0d real %0d want %0d",
                                      w.beam, w.elem, weight_real_i, w.re));
          if (weight_imag_i !== w.im)
            report_mismatch($sformatf("beam %0d elem %0d imag %0d want %0d",
                                      w.beam, w.elem, weight_imag_i, w.im));
          if (last_i !== w.last)
            report_mismatch($sformatf("elem %0d last %0b want %0b",
                                      w.elem, last_i, w.last));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (stored_az[beam_i] != azimuth_angle_i ||
            stored_el[beam_i] != elevation_angle_i) begin
          stored_az[beam_i] = azimuth_angle_i;
          stored_el[beam_i] = elevation_angle_i;
          predict_weights(beam_i, azimuth_angle_i, elevation_angle_i);
        end
      end
    end
  end

endmodule

// File: sim/planar_array_steering_weights_test.sv
// testbench top: clock, reset, stimulus, config phases, watchdog and verdict
`timescale 1ns / 100ps

module planar_array_steering_weights_test;
  import pasw_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 800;

  logic                       clk_i, rst_ni;
  logic                       cfg_we_i;
  logic [CFG_IDX_W-1:0]       cfg_index_i;
  logic [SPACING_W-1:0]       cfg_data_i;
  logic                       in_valid_i, in_ready_o;
  logic [BEAM_W-1:0]          beam_i;
  logic signed [ANGLE_W-1:0]  azimuth_angle_i, elevation_angle_i;
  logic                       out_valid_o, out_ready_i;
  logic [BEAM_W-1:0]          beam_out_o;
  logic [ELEM_W-1:0]          element_o;
  logic signed [WEIGHT_W-1:0] weight_real_o, weight_imag_o;
  logic                       last_o;
  int                         fail_count, pending;
  int                         send_idle_pct, recv_stall_pct;
  int                         quiet_cycles;
  logic signed [ANGLE_W-1:0]  sent_az [BEAMS];
  logic signed [ANGLE_W-1:0]  sent_el [BEAMS];

  planar_array_steering_weights u_top (.*);

  planar_array_steering_weights_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .beam_i, .azimuth_angle_i,
    .elevation_angle_i, .out_valid_i(out_valid_o), .out_ready_i,
    .beam_out_i(beam_out_o), .element_i(element_o),
    .weight_real_i(weight_real_o), .weight_imag_i(weight_imag_o),
    .last_i(last_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver stalls
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout");
      $display("Some tests failed");
      $finish;
    end
  end

  // one input word; valid stays up unless the sender idles
  task automatic send_word(input logic [BEAM_W-1:0] b,
                           input logic signed [ANGLE_W-1:0] az,
                           input logic signed [ANGLE_W-1:0] el);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    beam_i            <= b;
    azimuth_angle_i   <= az;
    elevation_angle_i <= el;
    sent_az[b] = az;
    sent_el[b] = el;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // wait for all weights, then for any update still in flight
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SPACING_W-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic signed [ANGLE_W-1:0] rand_angle();
    if ($urandom_range(9) == 0) return ANGLE_W'($urandom);
    return ANGLE_W'($signed($urandom_range(46080)) - 23040);
  endfunction

  // mostly fresh angles, some repeats of the last pair sent for a beam
  task automatic random_words(input int n);
    logic [BEAM_W-1:0] b;
    for (int i = 0; i < n; i++) begin
      b = BEAM_W'($urandom_range(BEAMS - 1));
      case ($urandom_range(9))
        0, 1:    send_word(b, sent_az[b], sent_el[b]);
        2:       send_word(b, sent_az[b], rand_angle());
        3:       send_word(b, rand_angle(), sent_el[b]);
        default: send_word(b, rand_angle(), rand_angle());
      endcase
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = REG_HSPACE;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    beam_i            = '0;
    azimuth_angle_i   = '0;
    elevation_angle_i = '0;
    out_ready_i       = 1'b0;
    quiet_cycles      = 0;
    send_idle_pct     = 10;
    recv_stall_pct    = 84;
    for (int b = 0; b < BEAMS; b++) begin
      sent_az[b] = reset_az(b[BEAM_W-1:0]);
      sent_el[b] = reset_el(b[BEAM_W-1:0]);
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: stored reset pairs, repeats, angle extremes, wrap
    send_word(2'd0, -16'sd512, 16'sd0);
    send_word(2'd2, 16'sd0, 16'sd512);
    send_word(2'd1, 16'sd0, 16'sd0);
    send_word(2'd1, 16'sd0, 16'sd0);
    send_word(2'd3, 16'sd23040, 16'sd0);
    send_word(2'd3, -16'sd23040, 16'sd0);
    send_word(2'd0, 16'sd0, 16'sd23040);
    send_word(2'd0, 16'sd0, -16'sd23040);
    send_word(2'd2, 16'sd11520, 16'sd11520);
    send_word(2'd2, -16'sd11520, -16'sd11520);
    send_word(2'd1, 16'sh7FFF, 16'sh8000);
    send_word(2'd1, 16'sh8000, 16'sh7FFF);
    send_word(2'd3, 16'sd1, -16'sd1);
    drain();

    // spacing extremes and an ignored index
    write_reg(REG_HSPACE, '1);
    write_reg(REG_VSPACE, '0);
    write_reg(REG_UNUSED, 18'h15555);
    send_word(2'd0, 16'sd5760, 16'sd2560);
    send_word(2'd1, -16'sd17000, 16'sd9000);
    drain();
    write_reg(REG_HSPACE, '0);
    write_reg(REG_VSPACE, '1);
    send_word(2'd0, 16'sd5761, 16'sd2560);
    send_word(2'd1, -16'sd17000, -16'sd9000);
    drain();

    // random with sender idling lightly and receiver heavily
    write_reg(REG_HSPACE, HSPACE_RESET);
    write_reg(REG_VSPACE, VSPACE_RESET);
    random_words(50);
    drain();

    // swapped idling, random spacings
    send_idle_pct  = 84;
    recv_stall_pct = 10;
    write_reg(REG_HSPACE, SPACING_W'($urandom));
    write_reg(REG_VSPACE, SPACING_W'($urandom));
    random_words(50);
    drain();

    // no idling
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_HSPACE, SPACING_W'($urandom_range(32768, 131072)));
    write_reg(REG_VSPACE, SPACING_W'($urandom_range(32768, 131072)));
    random_words(50);
    drain();

    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// File: sim.f
sv/pasw_pkg.sv
sv/pasw_trig.sv
sv/pasw_cell.sv
sv/planar_array_steering_weights.sv
sim/planar_array_steering_weights_checker.sv
sim/planar_array_steering_weights_test.sv
